>>> design/fpm_pkg.sv
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants of the single-precision multiplier pipeline.
// ----------------------------------------------------------------------------
package fpm_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [30:0] INF_BITS  = 31'h7F80_0000;
    localparam logic [9:0]  EXP_BIAS  = 10'd127;

    typedef enum logic [2:0] {
        ST_NORMAL   = 3'd0,
        ST_ZERO     = 3'd1,
        ST_OVF_NAN  = 3'd2,
        ST_UNF_NAN  = 3'd3,
        ST_INFINITY = 3'd4
    } status_t;

    // Operands after unpacking, carried through stage one.
    typedef struct packed {
        logic        sign;
        logic [9:0]  exp_sum;     // signed unbiased exponent sum
        status_t     early;       // ST_NORMAL or an early exception
        logic [23:0] sig_a;
        logic [23:0] sig_b;
    } unpack_t;

    // Product before rounding, carried through stage two.
    typedef struct packed {
        logic        sign;
        logic [9:0]  exp_sum;
        status_t     early;
        logic [47:0] prod;
    } mult_t;

endpackage

>>> design/fpm_unpack.sv
// ----------------------------------------------------------------------------
// fpm_unpack
// Splits both operands, sums the exponents and flags early exceptions.
// ----------------------------------------------------------------------------
module fpm_unpack
    import fpm_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output unpack_t     u
);

    logic [7:0] ea;
    logic [7:0] eb;
    logic [9:0] sum;

    always_comb
    begin
        ea  = a[30:23];
        eb  = b[30:23];
        sum = {2'b00, ea} + {2'b00, eb} - 10'd254;
        u.sign    = a[31] ^ b[31];
        u.exp_sum = sum;
        u.sig_a   = {1'b1, a[22:0]};
        u.sig_b   = {1'b1, b[22:0]};
        if (ea == 8'd0 || eb == 8'd0)
            u.early = ST_ZERO;
        else if ($signed(sum) > $signed(10'd128))
            u.early = ST_OVF_NAN;
        else if ($signed(sum) < $signed(-10'sd125))
            u.early = ST_UNF_NAN;
        else
            u.early = ST_NORMAL;
    end

endmodule

>>> design/fpm_round.sv
// ----------------------------------------------------------------------------
// fpm_round
// Normalizes, rounds to nearest-even and packs the result.
// ----------------------------------------------------------------------------
module fpm_round
    import fpm_pkg::*;
(
    input  mult_t       m,
    output logic [31:0] result,
    output status_t     stat
);

    logic        top;
    logic [23:0] keep;
    logic [23:0] rem;
    logic [23:0] half;
    logic        up;
    logic [24:0] rounded;
    logic [23:0] sig;
    logic [9:0]  e;

    always_comb
    begin
        top  = m.prod[47];
        keep = top ? m.prod[47:24] : m.prod[46:23];
        rem  = top ? m.prod[23:0] : {1'b0, m.prod[22:0]};
        half = top ? 24'h80_0000 : 24'h40_0000;
        up   = (rem > half) || (rem == half && keep[0]);
        rounded = {1'b0, keep} + {24'd0, up};
        sig  = rounded[24] ? rounded[24:1] : rounded[23:0];
        e    = m.exp_sum + {9'd0, top} + {9'd0, rounded[24]};
        if (m.early == ST_ZERO)
        begin
            result = 32'd0;
            stat   = ST_ZERO;
        end
        else if (m.early != ST_NORMAL)
        begin
            result = QNAN_BITS;
            stat   = m.early;
        end
        else if ($signed(e) > $signed(10'd127))
        begin
            result = {m.sign, INF_BITS};
            stat   = ST_INFINITY;
        end
        else
        begin
            result = {m.sign, 8'(e + EXP_BIAS), sig[22:0]};
            stat   = ST_NORMAL;
        end
    end

endmodule

>>> design/float32_multiplier.sv
// ----------------------------------------------------------------------------
// float32_multiplier
// Single-precision multiplier with flushed subnormals, three stages deep.
// ----------------------------------------------------------------------------
// Operand pairs arrive on the in channel (in_valid, in_ready) and results
// leave on the out channel (out_valid, out_ready); each side moves one
// transfer per cycle when valid and ready are both high.
// From input transfer to output valid, stage one unpacks and checks
// exponents, stage two runs the 24x24 significand multiply and stage three
// rounds and packs into the output register. Throughput is one pair per
// cycle while out_ready stays high; the multiplier stage sets the clock.
// Reset clears all stage valid bits, so the pipeline comes up empty.
// When the receiver stalls, the whole pipeline holds, except that empty
// stages still fill, so bubbles are squeezed out and nothing is lost or
// repeated.
// ----------------------------------------------------------------------------
module float32_multiplier
    import fpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] multiplicand_bits,
    input  logic [31:0] multiplier_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] product_bits,
    output logic [2:0]  status
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;
    unpack_t     u_next, u_reg;
    mult_t       m_next, m_reg;
    logic [31:0] res_next, res_reg;
    status_t     st_next, st_reg;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    fpm_unpack u_unpack (.a(multiplicand_bits), .b(multiplier_bits), .u(u_next));

    always_comb
    begin
        m_next.sign    = u_reg.sign;
        m_next.exp_sum = u_reg.exp_sum;
        m_next.early   = u_reg.early;
        m_next.prod    = u_reg.sig_a * u_reg.sig_b;
    end

    fpm_round u_round (.m(m_reg), .result(res_next), .stat(st_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid) u_reg <= u_next;
        if (en2 && v1_reg) m_reg <= m_next;
        if (en3 && v2_reg)
        begin
            res_reg <= res_next;
            st_reg  <= st_next;
        end
    end

    assign out_valid    = v3_reg;
    assign product_bits = res_reg;
    assign status       = st_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product_bits))
        else $error("stalled result changed");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'd4)
        else $error("status out of range");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ZERO |-> product_bits == 32'd0)
        else $error("zero result not zero");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && en3 |=> v3_reg)
        else $error("stage two item lost");

endmodule

>>> dv/float32_multiplier_tb.sv
// ----------------------------------------------------------------------------
// float32_multiplier_tb
// Self-checking testbench of the single-precision multiplier pipeline.
// ----------------------------------------------------------------------------
// Operand pairs are driven on the in channel under random idling on both
// sides. A product predictor works out each expected bit pattern and status,
// and a scoreboard compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module float32_multiplier_tb;
    import fpm_pkg::*;

    typedef struct packed {
        logic [31:0] bits;
        status_t     stat;
    } product_t;

    class product_board;
        product_t pending[$];
        int       errors;

        function product_t predict_product(logic [31:0] a, logic [31:0] b);
            product_t  r;
            logic      sgn;
            int        ea;
            int        eb;
            int        esum;
            logic [47:0] prod;
            logic [24:0] keep;
            logic [23:0] rem;
            logic [23:0] half;
            sgn = a[31] ^ b[31];
            ea = int'(a[30:23]);
            eb = int'(b[30:23]);
            if (ea == 0 || eb == 0)
            begin
                r.bits = 32'h0;
                r.stat = ST_ZERO;
                return r;
            end
            esum = (ea - 127) + (eb - 127);
            if (esum > 128)
            begin
                r.bits = QNAN_BITS;
                r.stat = ST_OVF_NAN;
                return r;
            end
            if (esum < -125)
            begin
                r.bits = QNAN_BITS;
                r.stat = ST_UNF_NAN;
                return r;
            end
            prod = {24'h0, 1'b1, a[22:0]} * {24'h0, 1'b1, b[22:0]};
            if (prod[47])
            begin
                keep = {1'b0, prod[47:24]};
                rem = prod[23:0];
                half = 24'h80_0000;
                esum = esum + 1;
            end
            else
            begin
                keep = {1'b0, prod[46:23]};
                rem = {1'b0, prod[22:0]};
                half = 24'h40_0000;
            end
            if (rem > half || (rem == half && keep[0]))
                keep = keep + 25'd1;
            if (keep[24])
            begin
                keep = keep >> 1;
                esum = esum + 1;
            end
            if (esum > 127)
            begin
                r.bits = {sgn, INF_BITS};
                r.stat = ST_INFINITY;
                return r;
            end
            r.bits = {sgn, 8'(esum + 127), keep[22:0]};
            r.stat = ST_NORMAL;
            return r;
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending.push_back(predict_product(a, b));
        endfunction

        function void check_product(logic [31:0] bits, logic [2:0] stat);
            product_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected product %h status %0d", $time, bits, stat);
                return;
            end
            e = pending.pop_front();
            if (bits !== e.bits)
            begin
                errors++;
                $display("%0t: product_bits expected %h actual %h", $time, e.bits, bits);
            end
            if (stat !== e.stat)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.stat, stat);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] multiplicand_bits;
    logic [31:0] multiplier_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] product_bits;
    logic [2:0]  status;

    product_board board;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    longint      cycle_count;

    float32_multiplier DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .multiplicand_bits(multiplicand_bits),
        .multiplier_bits(multiplier_bits),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .product_bits(product_bits),
        .status(status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Handshake signals only change at rising edges, so a transfer seen at the
    // falling edge completes at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_product(product_bits, status);
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0: v[30:23] = 8'($urandom_range(100, 154));
            1: v[30:23] = 8'($urandom_range(1, 3));
            2: v[30:23] = 8'($urandom_range(252, 255));
            3: v[30:23] = 8'd0;
            4: v[30:23] = 8'($urandom_range(60, 200));
            default: v[30:23] = 8'($urandom_range(110, 145));
        endcase
        return v;
    endfunction

    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        bit accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        multiplicand_bits <= a;
        multiplier_bits <= b;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = in_ready;
            @(posedge clk);
        end
        board.note_operands(a, b);
    endtask

    task automatic finish_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] dir_a[$];
        logic [31:0] dir_b[$];
        board = new();
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        multiplicand_bits = '0;
        multiplier_bits = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_a = '{32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 32'h807F_FFFF,
                  32'h7F7F_FFFF, 32'h7F80_0000, 32'h0080_0000, 32'h0080_0000,
                  32'h3FFF_FFFF, 32'h3FC0_0000, 32'h7F00_0000, 32'hFFFF_FFFF,
                  32'h3F80_0001, 32'h4000_0000, 32'hC040_0000, 32'h3F80_0000,
                  32'h7FFF_FFFF, 32'h00FF_FFFF, 32'h3FFF_FFFF, 32'hBF80_0001};
        dir_b = '{32'h3F80_0000, 32'h3F80_0000, 32'h8000_0001, 32'h3F80_0000,
                  32'h7F7F_FFFF, 32'h7F80_0000, 32'h0080_0000, 32'h1080_0000,
                  32'h3FFF_FFFF, 32'h3FC0_0000, 32'h4000_0000, 32'hFFFF_FFFF,
                  32'h3F80_0001, 32'h4080_0000, 32'h4040_0000, 32'h3F7F_FFFF,
                  32'h0100_0000, 32'h3F00_0000, 32'h3F00_0001, 32'h3F80_0003};
        foreach (dir_a[i])
            send_pair(dir_a[i], dir_b[i]);
        finish_sending();
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
            for (int n = 0; n < 480; n++)
            begin
                if (phase == 2 && n == 100)
                begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (60) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (n == 240)
                begin
                    finish_sending();
                    drain();
                end
                send_pair(random_operand(), random_operand());
            end
            finish_sending();
            drain();
        end

        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/fpm_pkg.sv
design/fpm_unpack.sv
design/fpm_round.sv
design/float32_multiplier.sv
dv/float32_multiplier_tb.sv
